[src/frustum_cull_test_defines.svh]
// ============================================================================
// frustum_cull_test_defines.svh
// Assertion macros shared by the frustum cull RTL. Empty when SYNTH is set.
// ============================================================================
`ifndef FRUSTUM_CULL_TEST_DEFINES_SVH
`define FRUSTUM_CULL_TEST_DEFINES_SVH

`ifndef SYNTH
// Checked on aclk, masked while aresetn is low
`define FCT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// Checked on aclk, also through reset
`define FCT_ASSERT_NORST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define FCT_ASSERT(lbl, prop, msg)
`define FCT_ASSERT_NORST(lbl, prop, msg)
`endif

`endif

[src/fcull_pkg.sv]
// ============================================================================
// fcull_pkg
// Types and constants of the six-plane frustum cull pipeline.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package fcull_pkg;

    // Plane set
    localparam int NUM_PLANE_REGS = 6;
    localparam int PLANE_COUNT    = 6;
    localparam int FAR_PLANE      = 1;
    localparam int PIDX_W         = $clog2(NUM_PLANE_REGS);

    // Config port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Query fields
    localparam int ACT_W   = 3;
    localparam int COORD_W = 16;
    localparam int EXT_W   = 15;
    localparam int COEF_W  = 16;

    // Arithmetic widths: products carry 14 fraction bits
    localparam int D_SHIFT = 14;
    localparam int PROD_W  = 2 * COEF_W;          // signed coef * signed coord
    localparam int MAG_W   = COEF_W + EXT_W;      // |coef| * extent
    localparam int VAL_W   = PROD_W + 2;          // three products plus d
    localparam int REACH_W = MAG_W + 2;           // three magnitudes
    localparam int SUM_W   = VAL_W + 2;           // value plus reach

    // Query kinds
    localparam logic [ACT_W-1:0] ACT_POINT   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_CUBE    = 3'd1;
    localparam logic [ACT_W-1:0] ACT_SPHERE  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_BOX     = 3'd3;
    localparam logic [ACT_W-1:0] ACT_FAR_BOX = 3'd4;

    // Register packing: d[63:48] c[47:32] b[31:16] a[15:0]
    typedef struct packed {
        logic signed [COEF_W-1:0] d;
        logic signed [COEF_W-1:0] c;
        logic signed [COEF_W-1:0] b;
        logic signed [COEF_W-1:0] a;
    } plane_t;

    // Load enables of the two arithmetic stages
    typedef struct packed {
        logic s1;
        logic s2;
    } stage_en_t;

endpackage

`default_nettype wire

[src/fcull_plane.sv]
// ============================================================================
// fcull_plane
// One plane's arithmetic: center value a*x+b*y+c*z+d and box reach
// |a|*ex+|b|*ey+|c|*ez, over two register stages.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module fcull_plane import fcull_pkg::*; (
    input  wire logic                      aclk,
    input  wire plane_t                    plane,
    input  wire stage_en_t                 en,
    input  wire logic signed [COORD_W-1:0] cx,
    input  wire logic signed [COORD_W-1:0] cy,
    input  wire logic signed [COORD_W-1:0] cz,
    input  wire logic        [EXT_W-1:0]   ex,
    input  wire logic        [EXT_W-1:0]   ey,
    input  wire logic        [EXT_W-1:0]   ez,
    output logic signed      [VAL_W-1:0]   val_center,
    output logic             [REACH_W-1:0] box_reach
);

    logic [COEF_W-1:0] a_mag;
    logic [COEF_W-1:0] b_mag;
    logic [COEF_W-1:0] c_mag;
    logic signed [VAL_W-1:0] d_term;

    logic signed [PROD_W-1:0] prod_x_reg;
    logic signed [PROD_W-1:0] prod_y_reg;
    logic signed [PROD_W-1:0] prod_z_reg;
    logic        [MAG_W-1:0]  mag_x_reg;
    logic        [MAG_W-1:0]  mag_y_reg;
    logic        [MAG_W-1:0]  mag_z_reg;
    logic signed [VAL_W-1:0]  val_reg;
    logic        [REACH_W-1:0] reach_reg;

    // Coefficient magnitudes; -32768 maps to 32768 in 16 unsigned bits
    always_comb begin
        a_mag = plane.a[COEF_W-1] ? (~plane.a + 1'b1) : plane.a;
        b_mag = plane.b[COEF_W-1] ? (~plane.b + 1'b1) : plane.b;
        c_mag = plane.c[COEF_W-1] ? (~plane.c + 1'b1) : plane.c;
    end

    // Stage 1: exact products
    always_ff @(posedge aclk) begin
        if (en.s1) begin
            prod_x_reg <= plane.a * cx;
            prod_y_reg <= plane.b * cy;
            prod_z_reg <= plane.c * cz;
            mag_x_reg  <= a_mag * ex;
            mag_y_reg  <= b_mag * ey;
            mag_z_reg  <= c_mag * ez;
        end
    end

    // d aligned to 14 fraction bits
    assign d_term = VAL_W'(plane.d) <<< D_SHIFT;

    // Stage 2: plane sums
    always_ff @(posedge aclk) begin
        if (en.s2) begin
            val_reg   <= VAL_W'(prod_x_reg) + VAL_W'(prod_y_reg)
                       + VAL_W'(prod_z_reg) + d_term;
            reach_reg <= REACH_W'(mag_x_reg) + REACH_W'(mag_y_reg)
                       + REACH_W'(mag_z_reg);
        end
    end

    assign val_center = val_reg;
    assign box_reach  = reach_reg;

endmodule

`default_nettype wire

[src/frustum_cull_test.sv]
// Frustum cull test: point, sphere, cube and box queries against six planes.
// Registered stages from input accept to m_valid: products, sums, compare.
// Throughput: one word per cycle; a stalled output backs up stage by stage.
// Reset (aresetn low, synchronous): pipeline empties, all planes clear to 0.
// cfg_ready is always high; write planes only while the pipe is idle (not enforced).
// ============================================================================
// frustum_cull_test
// Top level: plane registers, three-stage valid/ready pipeline and per-plane
// reject decision.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
`include "frustum_cull_test_defines.svh"

module frustum_cull_test import fcull_pkg::*; (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    // Plane configuration
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [CFG_DATA_W-1:0]     cfg_data,
    // Query input
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [ACT_W-1:0]          s_action,
    input  wire logic signed [COORD_W-1:0] s_center_x,
    input  wire logic signed [COORD_W-1:0] s_center_y,
    input  wire logic signed [COORD_W-1:0] s_center_z,
    input  wire logic [EXT_W-1:0]          s_extent_x,
    input  wire logic [EXT_W-1:0]          s_extent_y,
    input  wire logic [EXT_W-1:0]          s_extent_z,
    // Result output
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic                           m_visible
);

    plane_t plane_reg [NUM_PLANE_REGS];

    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic v3_reg, v3_next;
    logic rdy1, rdy2, rdy3;
    stage_en_t en;

    logic [ACT_W-1:0] act1_reg, act2_reg;
    logic [EXT_W-1:0] ext1_reg, ext2_reg;
    logic vis_reg, vis_next;

    logic [EXT_W-1:0] ey_sel, ez_sel;

    logic signed [VAL_W-1:0]   val_center [NUM_PLANE_REGS];
    logic        [REACH_W-1:0] box_reach  [NUM_PLANE_REGS];

    logic [NUM_PLANE_REGS-1:0] pt_neg, sph_neg, box_neg;
    logic                      far_neg;
    logic signed [SUM_W-1:0]   sph_term;

    // Config writes: indexes beyond the plane set are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_PLANE_REGS; i++) begin
                plane_reg[i] <= '0;
            end
        end else if (cfg_valid && cfg_index < CFG_IDX_W'(NUM_PLANE_REGS)) begin
            plane_reg[cfg_index[PIDX_W-1:0]] <= plane_t'(cfg_data);
        end
    end

    // Ready chain: a stage loads when empty or when the next one moves
    assign rdy3    = !v3_reg || m_ready;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;

    assign en.s1 = s_valid && rdy1;
    assign en.s2 = v1_reg && rdy2;

    always_comb begin
        v1_next = rdy1 ? s_valid : v1_reg;
        v2_next = rdy2 ? v1_reg  : v2_reg;
        v3_next = rdy3 ? v2_reg  : v3_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    // A cube uses its one half-size on every axis
    assign ey_sel = (s_action == ACT_CUBE) ? s_extent_x : s_extent_y;
    assign ez_sel = (s_action == ACT_CUBE) ? s_extent_x : s_extent_z;

    // Side-band carried along with the arithmetic
    always_ff @(posedge aclk) begin
        if (en.s1) begin
            act1_reg <= s_action;
            ext1_reg <= s_extent_x;
        end
        if (en.s2) begin
            act2_reg <= act1_reg;
            ext2_reg <= ext1_reg;
        end
    end

    // Per-plane arithmetic
    for (genvar p = 0; p < NUM_PLANE_REGS; p++) begin : g_plane
        fcull_plane u_plane (
            .aclk       (aclk),
            .plane      (plane_reg[p]),
            .en         (en),
            .cx         (s_center_x),
            .cy         (s_center_y),
            .cz         (s_center_z),
            .ex         (s_extent_x),
            .ey         (ey_sel),
            .ez         (ez_sel),
            .val_center (val_center[p]),
            .box_reach  (box_reach[p])
        );
    end

    // Stage 3: per-plane reject flags; a box is out when its farthest
    // corner toward the plane is still negative
    assign sph_term = $signed({{(SUM_W-EXT_W){1'b0}}, ext2_reg}) <<< D_SHIFT;

    always_comb begin
        far_neg = 1'b0;
        for (int p = 0; p < NUM_PLANE_REGS; p++) begin
            pt_neg[p]  = val_center[p][VAL_W-1];
            sph_neg[p] = (SUM_W'(val_center[p]) + sph_term) < 0;
            box_neg[p] = (SUM_W'(val_center[p])
                         + $signed({{(SUM_W-REACH_W){1'b0}}, box_reach[p]})) < 0;
            // far-only box ignores the plane count
            if (p == FAR_PLANE) begin
                far_neg = box_neg[p];
            end
            if (p >= PLANE_COUNT) begin
                pt_neg[p]  = 1'b0;
                sph_neg[p] = 1'b0;
                box_neg[p] = 1'b0;
            end
        end
    end

    always_comb begin
        case (act2_reg)
            ACT_POINT:              vis_next = !(|pt_neg);
            ACT_SPHERE:             vis_next = !(|sph_neg);
            ACT_CUBE, ACT_BOX:      vis_next = !(|box_neg);
            ACT_FAR_BOX:            vis_next = !far_neg;
            default:                vis_next = 1'b1;
        endcase
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (v2_reg && rdy3) begin
            vis_reg <= vis_next;
        end
    end

    assign m_valid   = v3_reg;
    assign m_visible = vis_reg;

    // Checks
    `FCT_ASSERT_NORST(a_reset_empty, !aresetn |=> !v1_reg && !v2_reg && !v3_reg, "pipeline not empty after reset")
    `FCT_ASSERT(a_full_when_blocked, !s_ready |-> v1_reg && v2_reg && v3_reg && !m_ready, "input blocked with a bubble in the pipe")
    `FCT_ASSERT(a_stage2_moves, v1_reg && rdy2 |=> v2_reg, "stage 1 word lost on the way to stage 2")
    `FCT_ASSERT(a_undef_visible, v2_reg && rdy3 && act2_reg > ACT_FAR_BOX |=> m_visible, "undefined query kind was culled")

endmodule

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for the six-plane frustum cull pipeline. Queries are
// driven on a valid/ready channel from a queue, each accepted word is run
// through a local visibility predictor, and every result word is compared
// in order. Phases vary the plane set and the amount of idling on both sides.
// ============================================================================

module tb_top import fcull_pkg::*; ();

    localparam int     TIMEOUT_CYCLES = 200000;
    localparam int     DRAIN_CYCLES   = 8;
    localparam int     HOLD_CYCLES    = 200;
    localparam longint D_SCALE        = longint'(1) << D_SHIFT;

    typedef struct {
        logic [ACT_W-1:0]          action;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cz;
        logic [EXT_W-1:0]          ex;
        logic [EXT_W-1:0]          ey;
        logic [EXT_W-1:0]          ez;
    } query_t;

    typedef struct {
        logic [ACT_W-1:0] action;
        bit               visible;
    } visible_exp_t;

    // Clock, reset and DUT ports
    logic                      aclk       = 1'b0;
    logic                      aresetn    = 1'b0;
    logic                      cfg_valid  = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index  = '0;
    logic [CFG_DATA_W-1:0]     cfg_data   = '0;
    logic                      s_valid    = 1'b0;
    logic                      s_ready;
    logic [ACT_W-1:0]          s_action   = '0;
    logic signed [COORD_W-1:0] s_center_x = '0;
    logic signed [COORD_W-1:0] s_center_y = '0;
    logic signed [COORD_W-1:0] s_center_z = '0;
    logic [EXT_W-1:0]          s_extent_x = '0;
    logic [EXT_W-1:0]          s_extent_y = '0;
    logic [EXT_W-1:0]          s_extent_z = '0;
    logic                      m_valid;
    logic                      m_ready    = 1'b0;
    logic                      m_visible;

    // Bench state
    query_t         query_q[$];
    visible_exp_t   visible_q[$];
    logic [63:0]    plane_mdl[NUM_PLANE_REGS];
    logic [63:0]    plane_set[NUM_PLANE_REGS];
    int             errors         = 0;
    int             cycle_cnt      = 0;
    int             send_idle_pct  = 0;
    int             recv_stall_pct = 0;
    bit             in_taken       = 1'b0;
    bit             hold_req       = 1'b0;
    bit             hold_done      = 1'b0;
    int             hold_cnt       = 0;
    query_t         drv_query;
    query_t         cap_query;
    visible_exp_t   cap_exp;

    frustum_cull_test dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_action   (s_action),
        .s_center_x (s_center_x),
        .s_center_y (s_center_y),
        .s_center_z (s_center_z),
        .s_extent_x (s_extent_x),
        .s_extent_y (s_extent_y),
        .s_extent_z (s_extent_z),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_visible  (m_visible)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Visibility predictor
    // ------------------------------------------------------------------------

    // Signed distance of (x,y,z) to plane p, 14 fraction bits
    function automatic longint plane_value(int p, longint x, longint y, longint z);
        logic [63:0] r;
        longint      a, b, c, d;
        r = plane_mdl[p];
        a = $signed(r[15:0]);
        b = $signed(r[31:16]);
        c = $signed(r[47:32]);
        d = $signed(r[63:48]);
        return a * x + b * y + c * z + d * D_SCALE;
    endfunction

    // All eight corners strictly behind plane p
    function automatic bit box_culled(int p, longint cx, longint cy, longint cz,
                                      longint ex, longint ey, longint ez);
        longint x, y, z;
        for (int k = 0; k < 8; k++) begin
            x = k[0] ? cx + ex : cx - ex;
            y = k[1] ? cy + ey : cy - ey;
            z = k[2] ? cz + ez : cz - ez;
            if (plane_value(p, x, y, z) >= 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic bit predict_visible(query_t q);
        longint cx, cy, cz, ex, ey, ez;
        bit     vis;
        cx  = q.cx;
        cy  = q.cy;
        cz  = q.cz;
        ex  = q.ex;
        ey  = q.ey;
        ez  = q.ez;
        vis = 1'b1;
        case (q.action)
            ACT_POINT: begin
                for (int p = 0; p < PLANE_COUNT; p++)
                    if (plane_value(p, cx, cy, cz) < 0) vis = 1'b0;
            end
            ACT_CUBE: begin
                for (int p = 0; p < PLANE_COUNT; p++)
                    if (box_culled(p, cx, cy, cz, ex, ex, ex)) vis = 1'b0;
            end
            ACT_SPHERE: begin
                for (int p = 0; p < PLANE_COUNT; p++)
                    if (plane_value(p, cx, cy, cz) < -(ex * D_SCALE)) vis = 1'b0;
            end
            ACT_BOX: begin
                for (int p = 0; p < PLANE_COUNT; p++)
                    if (box_culled(p, cx, cy, cz, ex, ey, ez)) vis = 1'b0;
            end
            ACT_FAR_BOX: begin
                if (box_culled(FAR_PLANE, cx, cy, cz, ex, ey, ez)) vis = 1'b0;
            end
            default: ;  // undefined kinds are never culled
        endcase
        return vis;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic logic [63:0] make_plane(int a, int b, int c, int d);
        return {COEF_W'(d), COEF_W'(c), COEF_W'(b), COEF_W'(a)};
    endfunction

    function automatic logic [EXT_W-1:0] rand_extent();
        int sel;
        sel = $urandom_range(99);
        if (sel < 65)
            return EXT_W'($urandom_range(3000));
        else if (sel < 85)
            return EXT_W'($urandom);
        else if (sel < 93)
            return '0;
        else
            return EXT_W'(32767 - $urandom_range(3));
    endfunction

    // Mostly near the frustum, some anywhere in the coordinate range
    function automatic query_t rand_query();
        query_t q;
        if ($urandom_range(99) < 92)
            q.action = ACT_W'($urandom_range(4));
        else
            q.action = ACT_W'($urandom_range(7, 5));
        if ($urandom_range(99) < 70) begin
            q.cx = COORD_W'($urandom_range(16000) - 8000);
            q.cy = COORD_W'($urandom_range(16000) - 8000);
            q.cz = COORD_W'($urandom_range(22000) - 2000);
        end else begin
            q.cx = COORD_W'($urandom);
            q.cy = COORD_W'($urandom);
            q.cz = COORD_W'($urandom);
        end
        q.ex = rand_extent();
        q.ey = rand_extent();
        q.ez = rand_extent();
        return q;
    endfunction

    task automatic add_query(input logic [ACT_W-1:0] act, input int x, input int y,
                             input int z, input int ex, input int ey, input int ez);
        query_t q;
        q.action = act;
        q.cx     = COORD_W'(x);
        q.cy     = COORD_W'(y);
        q.cz     = COORD_W'(z);
        q.ex     = EXT_W'(ex);
        q.ey     = EXT_W'(ey);
        q.ez     = EXT_W'(ez);
        query_q.push_back(q);
    endtask

    task automatic add_random(input int count);
        for (int i = 0; i < count; i++)
            query_q.push_back(rand_query());
    endtask

    task automatic write_reg(input int idx, input logic [63:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_IDX_W'(idx);
        cfg_data  <= data;
        @(posedge aclk);
        while (cfg_ready !== 1'b1) @(posedge aclk);
    endtask

    // All six planes, then the two unused indexes with junk that must be dropped
    task automatic write_planes();
        for (int i = 0; i < NUM_PLANE_REGS; i++)
            write_reg(i, plane_set[i]);
        write_reg(6, {$urandom, $urandom});
        write_reg(7, {$urandom, $urandom});
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Queue empty, channel idle, every result back, then let the pipe settle
    task automatic wait_drained();
        @(posedge aclk);
        while (query_q.size() != 0 || s_valid || visible_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Query driver: next word goes out on the falling edge
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!s_valid || in_taken) begin
            if (query_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                drv_query = query_q.pop_front();
                s_valid    <= 1'b1;
                s_action   <= drv_query.action;
                s_center_x <= drv_query.cx;
                s_center_y <= drv_query.cy;
                s_center_z <= drv_query.cz;
                s_extent_x <= drv_query.ex;
                s_extent_y <= drv_query.ey;
                s_extent_z <= drv_query.ez;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result receiver, with a one-shot long hold-off to back up the pipe
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        if (hold_req && !hold_done) begin
            hold_cnt  = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_cnt > 0) begin
            hold_cnt = hold_cnt - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Capture and check on the rising edge
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        in_taken <= aresetn && s_valid && (s_ready === 1'b1);
        if (aresetn) begin
            // plane writes update the local copy
            if (cfg_valid && cfg_ready === 1'b1 && cfg_index < NUM_PLANE_REGS)
                plane_mdl[cfg_index] <= cfg_data;

            // result word against the oldest expectation
            if (m_valid === 1'b1 && m_ready) begin
                if (visible_q.size() == 0) begin
                    errors = errors + 1;
                    $display("%0t: result word with none expected, actual visible %b",
                             $time, m_visible);
                end else begin
                    cap_exp = visible_q.pop_front();
                    if (m_visible !== cap_exp.visible) begin
                        errors = errors + 1;
                        $display("%0t: visible mismatch (action %0d) expected %b actual %b",
                                 $time, cap_exp.action, cap_exp.visible, m_visible);
                    end
                end
            end

            // accepted query word
            if (s_valid && s_ready === 1'b1) begin
                cap_query.action = s_action;
                cap_query.cx     = s_center_x;
                cap_query.cy     = s_center_y;
                cap_query.cz     = s_center_z;
                cap_query.ex     = s_extent_x;
                cap_query.ey     = s_extent_y;
                cap_query.ez     = s_extent_z;
                cap_exp.action   = s_action;
                cap_exp.visible  = predict_visible(cap_query);
                visible_q.push_back(cap_exp);
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= TIMEOUT_CYCLES) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        for (int i = 0; i < NUM_PLANE_REGS; i++)
            plane_mdl[i] = '0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Planes still at reset: all-zero planes reject nothing
        add_query(ACT_POINT, 0, 0, 0, 0, 0, 0);
        add_query(ACT_POINT, -32768, 32767, -32768, 0, 0, 0);
        add_query(ACT_CUBE, 32767, -32768, 32767, 32767, 0, 0);
        add_query(ACT_SPHERE, -32768, -32768, -32768, 32767, 0, 0);
        add_query(ACT_FAR_BOX, 1000, -1000, 5000, 32767, 32767, 32767);
        add_query(3'd7, 123, 456, 789, 10, 20, 30);
        wait_drained();

        // Symmetric frustum, depth 16..16000, 90 degree cone
        plane_set[0] = make_plane(0, 0, 16384, -16);
        plane_set[1] = make_plane(0, 0, -16384, 16000);
        plane_set[2] = make_plane(11585, 0, 11585, 0);
        plane_set[3] = make_plane(-11585, 0, 11585, 0);
        plane_set[4] = make_plane(0, -11585, 11585, 0);
        plane_set[5] = make_plane(0, 11585, 11585, 0);
        write_planes();

        // Touching vs. just outside near and far
        add_query(ACT_POINT, 0, 0, 16, 0, 0, 0);
        add_query(ACT_POINT, 0, 0, 15, 0, 0, 0);
        add_query(ACT_POINT, 0, 0, 16000, 0, 0, 0);
        add_query(ACT_POINT, 0, 0, 16001, 0, 0, 0);
        // sphere touching near with its surface
        add_query(ACT_SPHERE, 0, 0, 0, 16, 0, 0);
        add_query(ACT_SPHERE, 0, 0, 0, 15, 0, 0);
        // cube whose top corner reaches the near plane exactly
        add_query(ACT_CUBE, 0, 0, -100, 116, 7, 9);
        add_query(ACT_CUBE, 0, 0, -100, 115, 0, 0);
        add_query(ACT_BOX, 5000, 0, 1000, 4000, 0, 0);
        add_query(ACT_BOX, -32768, -32768, -32768, 32767, 32767, 32767);
        add_query(ACT_BOX, 32767, 32767, 32767, 0, 0, 0);
        // far-only box: touching, just past, and behind the near plane
        add_query(ACT_FAR_BOX, 0, 0, 20000, 0, 0, 4000);
        add_query(ACT_FAR_BOX, 0, 0, 20000, 0, 0, 3999);
        add_query(ACT_FAR_BOX, 0, 0, -5000, 0, 0, 0);
        // undefined kinds
        add_query(3'd5, -32768, 0, -32768, 0, 0, 0);
        add_query(3'd6, 32767, 32767, 32767, 32767, 32767, 32767);
        add_query(3'd7, 0, 0, 0, 0, 0, 0);
        add_query(ACT_POINT, -32768, -32768, -32768, 32767, 32767, 32767);
        add_query(ACT_POINT, 32767, 32767, 32767, 0, 0, 0);
        add_query(ACT_SPHERE, 32767, 32767, 32767, 32767, 0, 0);
        wait_drained();

        // Random, no idling, with a long receiver hold-off at the start
        hold_req = 1'b1;
        add_random(110);
        wait_drained();

        // Extreme coefficient patterns; sender mostly idle
        plane_set[0] = 64'h7FFF_7FFF_7FFF_7FFF;
        plane_set[1] = 64'h8000_8000_8000_8000;
        plane_set[2] = 64'hFFFF_FFFF_FFFF_FFFF;
        plane_set[3] = make_plane(16'h7FFF, 16'h8000, 0, 16'h7FFF);
        plane_set[4] = '0;
        plane_set[5] = make_plane(0, 0, 16384, 16'h8000);
        write_planes();
        send_idle_pct  = 76;
        recv_stall_pct = 0;
        add_random(110);
        wait_drained();

        // Fully random planes; receiver mostly stalling
        for (int i = 0; i < NUM_PLANE_REGS; i++)
            plane_set[i] = {$urandom, $urandom};
        write_planes();
        send_idle_pct  = 0;
        recv_stall_pct = 76;
        add_random(110);
        wait_drained();

        // Offset, narrower frustum; light idling on both sides
        plane_set[0] = make_plane(0, 0, 16384, -160);
        plane_set[1] = make_plane(0, 0, -16384, 8000);
        plane_set[2] = make_plane(14189, 0, 8192, 320);
        plane_set[3] = make_plane(-14189, 0, 8192, 320);
        plane_set[4] = make_plane(0, -13377, 9459, -48);
        plane_set[5] = make_plane(0, 13377, 9459, -48);
        write_planes();
        send_idle_pct  = 13;
        recv_stall_pct = 13;
        add_random(110);
        wait_drained();

        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
